// File: hdl/tpm_pkg.sv
// Package: shared types, widths and constants for the touch raw-to-screen mapper.
package tpm_pkg;

    localparam int RAW_W      = 16;   // raw converter reading
    localparam int SIZE_W     = 12;   // screen size register
    localparam int NUM_W      = 28;   // |scale| * |raw - min| (12 x 16 bits)
    localparam int DEN_W      = 16;   // |max - min|
    localparam int COORD_W    = 32;   // signed screen coordinate
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Calibration points sit CAL_OFFSET in from each screen edge; CAL_MARGIN covers both edges.
    localparam logic [SIZE_W-1:0]         CAL_MARGIN = SIZE_W'(80);
    localparam logic signed [COORD_W-1:0] CAL_OFFSET = COORD_W'(40);
    localparam logic signed [COORD_W-1:0] COORD_BAD  = -COORD_W'(1);

    typedef enum logic [1:0] {
        ORIGIN_LU = 2'd0,
        ORIGIN_RU = 2'd1,
        ORIGIN_RD = 2'd2,
        ORIGIN_LD = 2'd3
    } origin_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAW_X_MIN     = 3'd0,
        CFG_RAW_X_MAX     = 3'd1,
        CFG_RAW_Y_MIN     = 3'd2,
        CFG_RAW_Y_MAX     = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5,
        CFG_ORIGIN_CORNER = 3'd6,
        CFG_SWAP_AXES     = 3'd7
    } cfg_index_t;

    localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = SIZE_W'(480);
    localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = SIZE_W'(272);

    typedef struct packed {
        logic [RAW_W-1:0]  raw_x_min;
        logic [RAW_W-1:0]  raw_x_max;
        logic [RAW_W-1:0]  raw_y_min;
        logic [RAW_W-1:0]  raw_y_max;
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] screen_height;
        origin_t           origin_corner;
        logic              swap_axes;
    } cfg_t;

    // One divide request: unsigned magnitudes plus the sign of the quotient.
    typedef struct packed {
        logic             neg;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num;
    } div_req_t;

    // Divider result for one axis.
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] quot;
    } div_res_t;

endpackage

// File: hdl/tpm_front.sv
// Front end: axis selection, magnitudes and the scale multiply (two stages).
module tpm_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [15:0]           raw_x,
    input  logic [15:0]           raw_y,
    input  tpm_pkg::cfg_t         cfg,
    output logic                  out_valid,
    output tpm_pkg::div_req_t     req_x,
    output tpm_pkg::div_req_t     req_y
);

    typedef struct packed {
        logic                         neg;
        logic [tpm_pkg::SIZE_W-1:0]   abs_scale;
        logic [tpm_pkg::RAW_W-1:0]    abs_diff;
        logic [tpm_pkg::DEN_W-1:0]    abs_den;
    } prep_t;

    // Sign of scale*(raw-lo)/(hi-lo) and the three magnitudes.
    function automatic prep_t prep_axis(
        input logic [tpm_pkg::RAW_W-1:0]  raw,
        input logic [tpm_pkg::RAW_W-1:0]  lo,
        input logic [tpm_pkg::RAW_W-1:0]  hi,
        input logic [tpm_pkg::SIZE_W-1:0] size
    );
        prep_t p;
        p.neg       = (size < tpm_pkg::CAL_MARGIN) ^ (raw < lo) ^ (hi < lo);
        p.abs_scale = (size >= tpm_pkg::CAL_MARGIN) ? (size - tpm_pkg::CAL_MARGIN)
                                                    : (tpm_pkg::CAL_MARGIN - size);
        p.abs_diff  = (raw >= lo) ? (raw - lo) : (lo - raw);
        p.abs_den   = (hi >= lo) ? (hi - lo) : (lo - hi);
        return p;
    endfunction

    logic  valid1_reg, valid2_reg;
    prep_t prep_x_reg, prep_y_reg;
    prep_t prep_x_next, prep_y_next;
    tpm_pkg::div_req_t req_x_reg, req_y_reg;
    tpm_pkg::div_req_t req_x_next, req_y_next;

    always_comb
    begin
        if (cfg.swap_axes)
        begin
            prep_x_next = prep_axis(raw_y, cfg.raw_y_min, cfg.raw_y_max, cfg.screen_width);
            prep_y_next = prep_axis(raw_x, cfg.raw_x_min, cfg.raw_x_max, cfg.screen_height);
        end
        else
        begin
            prep_x_next = prep_axis(raw_x, cfg.raw_x_min, cfg.raw_x_max, cfg.screen_width);
            prep_y_next = prep_axis(raw_y, cfg.raw_y_min, cfg.raw_y_max, cfg.screen_height);
        end
    end

    always_comb
    begin
        req_x_next.neg = prep_x_reg.neg;
        req_x_next.den = prep_x_reg.abs_den;
        req_x_next.num = tpm_pkg::NUM_W'(prep_x_reg.abs_scale)
                       * tpm_pkg::NUM_W'(prep_x_reg.abs_diff);
        req_y_next.neg = prep_y_reg.neg;
        req_y_next.den = prep_y_reg.abs_den;
        req_y_next.num = tpm_pkg::NUM_W'(prep_y_reg.abs_scale)
                       * tpm_pkg::NUM_W'(prep_y_reg.abs_diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_x_reg <= prep_x_next;
        prep_y_reg <= prep_y_next;
        req_x_reg  <= req_x_next;
        req_y_reg  <= req_y_next;
    end

    assign out_valid = valid2_reg;
    assign req_x     = req_x_reg;
    assign req_y     = req_y_reg;

endmodule

// File: hdl/tpm_divider.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
module tpm_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  tpm_pkg::div_req_t     req,
    output logic                  out_valid,
    output tpm_pkg::div_res_t     res
);

    localparam int N = tpm_pkg::NUM_W;
    localparam int D = tpm_pkg::DEN_W;

    typedef struct packed {
        logic         neg;
        logic [D-1:0] den;
        logic [D-1:0] rem;
        logic [N-1:0] work;   // dividend bits shift out, quotient bits shift in
    } div_stage_t;

    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t   r;
        logic [D:0]   shifted;
        logic [D+1:0] trial;
        r       = s;
        shifted = {s.rem, s.work[N-1]};
        trial   = {1'b0, shifted} - {2'b00, s.den};
        if (!trial[D+1])
        begin
            r.rem  = trial[D-1:0];
            r.work = {s.work[N-2:0], 1'b1};
        end
        else
        begin
            r.rem  = shifted[D-1:0];
            r.work = {s.work[N-2:0], 1'b0};
        end
        return r;
    endfunction

    div_stage_t stage_reg  [0:N];
    div_stage_t stage_next [0:N];
    logic [N:0] valid_reg;
    logic [N:0] valid_next;

    always_comb
    begin
        stage_next[0].neg  = req.neg;
        stage_next[0].den  = req.den;
        stage_next[0].rem  = '0;
        stage_next[0].work = req.num;
        valid_next[0]      = in_valid;
        for (int k = 0; k < N; k++)
        begin
            stage_next[k+1] = div_step(stage_reg[k]);
            valid_next[k+1] = valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= N; k++)
            stage_reg[k] <= stage_next[k];
    end

    assign out_valid = valid_reg[N];
    assign res.neg   = stage_reg[N].neg;
    assign res.quot  = stage_reg[N].work;

endmodule

// File: hdl/tpm_finish.sv
// Back end: sign and offset, then mirroring and the degenerate-span override.
module tpm_finish
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  tpm_pkg::div_res_t      res_x,
    input  tpm_pkg::div_res_t      res_y,
    input  tpm_pkg::cfg_t          cfg,
    output logic                   done,
    output logic signed [31:0]     screen_x,
    output logic signed [31:0]     screen_y,
    output logic                   valid_res
);

    localparam int W = tpm_pkg::COORD_W;

    function automatic logic signed [W-1:0] apply_offset(input tpm_pkg::div_res_t r);
        logic signed [W-1:0] q;
        q = $signed({{(W-tpm_pkg::NUM_W){1'b0}}, r.quot});
        return r.neg ? (tpm_pkg::CAL_OFFSET - q) : (tpm_pkg::CAL_OFFSET + q);
    endfunction

    logic                validA_reg, validB_reg;
    logic signed [W-1:0] coord_x_reg, coord_y_reg;
    logic signed [W-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic                ok_reg, ok_next;
    logic                mirror_x, mirror_y;
    logic signed [W-1:0] width_ext, height_ext;

    assign mirror_x   = (cfg.origin_corner == tpm_pkg::ORIGIN_RU)
                     || (cfg.origin_corner == tpm_pkg::ORIGIN_RD);
    assign mirror_y   = (cfg.origin_corner == tpm_pkg::ORIGIN_RD)
                     || (cfg.origin_corner == tpm_pkg::ORIGIN_LD);
    assign width_ext  = $signed({{(W-tpm_pkg::SIZE_W){1'b0}}, cfg.screen_width});
    assign height_ext = $signed({{(W-tpm_pkg::SIZE_W){1'b0}}, cfg.screen_height});

    always_comb
    begin
        ok_next = (cfg.raw_x_min != cfg.raw_x_max) && (cfg.raw_y_min != cfg.raw_y_max);
        sx_next = mirror_x ? (width_ext - coord_x_reg) : coord_x_reg;
        sy_next = mirror_y ? (height_ext - coord_y_reg) : coord_y_reg;
        if (!ok_next)
        begin
            sx_next = tpm_pkg::COORD_BAD;
            sy_next = tpm_pkg::COORD_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            validA_reg <= 1'b0;
            validB_reg <= 1'b0;
        end
        else
        begin
            validA_reg <= in_valid;
            validB_reg <= validA_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_x_reg <= apply_offset(res_x);
        coord_y_reg <= apply_offset(res_y);
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        ok_reg      <= ok_next;
    end

    assign done      = validB_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign valid_res = ok_reg;

endmodule

// File: hdl/touch_raw_to_screen_mapper.sv
// Top level: two-point linear touchscreen calibration, raw sample to screen coordinate.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  sample   | start, busy, raw_x, raw_y               | taken when start && !busy
//  result   | done, screen_x, screen_y, valid_res     | one-cycle strobe on done
//  config   | cfg_we, cfg_index, cfg_data             | written when cfg_we is high
//
// Each axis: coord = 40 + (size - 80) * (raw - min) / (max - min), quotient
// truncated toward zero, then mirrored as size - coord per the origin corner.
// The pipeline is 2 front stages (select/magnitudes, scale multiply),
// 29 divider stages (input register, then one quotient bit each for 28 bits),
// 2 finish stages (sign/offset, mirror). One transaction enters per cycle;
// busy is never raised.
// Reset clears the pipeline valid bits and loads the register defaults.
// Results are not held: the receiver must take each one in its done cycle.
module touch_raw_to_screen_mapper
(
    input  logic                clk,
    input  logic                rst_n,
    // sample channel
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         raw_x,
    input  logic [15:0]         raw_y,
    // result channel
    output logic                done,
    output logic signed [31:0]  screen_x,
    output logic signed [31:0]  screen_y,
    output logic                valid_res,
    // configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    tpm_pkg::cfg_t     cfg_reg, cfg_next;
    logic              front_valid;
    tpm_pkg::div_req_t req_x, req_y;
    logic              div_valid_x, div_valid_y;
    tpm_pkg::div_res_t res_x, res_y;

    // Fully pipelined: a new sample can be taken every cycle.
    assign busy = 1'b0;

    // Register writes, masked to each register's width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tpm_pkg::cfg_index_t'(cfg_index))
                tpm_pkg::CFG_RAW_X_MIN:     cfg_next.raw_x_min = cfg_data;
                tpm_pkg::CFG_RAW_X_MAX:     cfg_next.raw_x_max = cfg_data;
                tpm_pkg::CFG_RAW_Y_MIN:     cfg_next.raw_y_min = cfg_data;
                tpm_pkg::CFG_RAW_Y_MAX:     cfg_next.raw_y_max = cfg_data;
                tpm_pkg::CFG_SCREEN_WIDTH:
                    cfg_next.screen_width  = cfg_data[tpm_pkg::SIZE_W-1:0];
                tpm_pkg::CFG_SCREEN_HEIGHT:
                    cfg_next.screen_height = cfg_data[tpm_pkg::SIZE_W-1:0];
                tpm_pkg::CFG_ORIGIN_CORNER:
                    cfg_next.origin_corner = tpm_pkg::origin_t'(cfg_data[1:0]);
                tpm_pkg::CFG_SWAP_AXES:     cfg_next.swap_axes = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_x_min     <= '0;
            cfg_reg.raw_x_max     <= '0;
            cfg_reg.raw_y_min     <= '0;
            cfg_reg.raw_y_max     <= '0;
            cfg_reg.screen_width  <= tpm_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= tpm_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.origin_corner <= tpm_pkg::ORIGIN_LD;
            cfg_reg.swap_axes     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Axis select, magnitudes, scale multiply.
    tpm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .req_x     (req_x),
        .req_y     (req_y)
    );

    // One divider per screen axis, running in lockstep.
    tpm_divider u_div_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .req       (req_x),
        .out_valid (div_valid_x),
        .res       (res_x)
    );

    tpm_divider u_div_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .req       (req_y),
        .out_valid (div_valid_y),
        .res       (res_y)
    );

    // Sign, offset, mirror; zero span on either axis forces -1,-1 and clears valid_res.
    tpm_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid_x && div_valid_y),
        .res_x     (res_x),
        .res_y     (res_y),
        .cfg       (cfg_reg),
        .done      (done),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .valid_res (valid_res)
    );

endmodule
